// ===== rtl/core/hrrn_pkg.sv =====
// hrrn scheduler package: sizes, state encoding and controller/datapath bundles
package hrrn_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int NUM_W     = 8;
    localparam int ARR_W     = 16;
    localparam int BUR_W     = 16;
    localparam int TIME_W    = 21;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_CLEAR
    } hrrn_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic commit;
        logic clear;
    } hrrn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic all_done;
        logic final_seg;
    } hrrn_status_t;

endpackage

// ===== rtl/core/hrrn_datapath.sv =====
// hrrn scheduler datapath: process table, ratio comparison and segment results
module hrrn_datapath
    import hrrn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hrrn_cmd_t             cmd,
    input  logic [NUM_W-1:0]      in_number,
    input  logic [ARR_W-1:0]      in_arrival,
    input  logic [BUR_W-1:0]      in_burst,
    output hrrn_status_t          status,
    output logic                  seg_idle,
    output logic [NUM_W-1:0]      seg_number,
    output logic [TIME_W-1:0]     seg_start,
    output logic [TIME_W-1:0]     seg_completion,
    output logic [TIME_W-1:0]     seg_turnaround,
    output logic [TIME_W-1:0]     seg_waiting,
    output logic [TIME_W-1:0]     seg_response
);

    // table storage
    logic [ARR_W-1:0] arrival_mem [MAX_PROCS];
    logic [BUR_W-1:0] burst_mem   [MAX_PROCS];
    logic [NUM_W-1:0] number_mem  [MAX_PROCS];
    logic [MAX_PROCS-1:0] finished_reg, finished_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] done_reg, done_next;
    logic [TIME_W-1:0] clock_reg, clock_next;

    // scan state
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [TIME_W-1:0] bw_reg, bw_next;
    logic [BUR_W-1:0] bb_reg, bb_next;
    logic [ARR_W-1:0] ba_reg, ba_next;
    logic [ARR_W:0]   next_arr_reg, next_arr_next;

    logic [IDX_W-1:0] idx;
    logic [ARR_W-1:0] cur_a;
    logic [BUR_W-1:0] cur_b;
    logic [TIME_W-1:0] cur_w;
    logic [TIME_W:0]  lhs_sum, rhs_sum;
    logic [TIME_W+BUR_W:0] lhs, rhs;
    logic             eligible, better;

    assign idx   = idx_reg[IDX_W-1:0];
    assign cur_a = arrival_mem[idx];
    assign cur_b = (burst_mem[idx] == '0) ? BUR_W'(1) : burst_mem[idx];
    assign cur_w = clock_reg - TIME_W'(cur_a);
    assign eligible = !finished_reg[idx] && (TIME_W'(cur_a) <= clock_reg);
    // cross-product ratio compare, one candidate per cycle
    assign lhs_sum = {1'b0, cur_w} + (TIME_W+1)'(cur_b);
    assign rhs_sum = {1'b0, bw_reg} + (TIME_W+1)'(bb_reg);
    assign lhs = (TIME_W+BUR_W+1)'(lhs_sum * bb_reg);
    assign rhs = (TIME_W+BUR_W+1)'(rhs_sum * cur_b);
    assign better = !found_reg || (lhs > rhs) || ((lhs == rhs) && (cur_a < ba_reg));

    assign status.scan_done = (idx_reg == count_reg - CNT_W'(1)) || (count_reg == '0);
    assign status.all_done  = (done_reg == count_reg);
    // the pending commit finishes the last unfinished process
    assign status.final_seg = found_reg && ((done_reg + CNT_W'(1)) == count_reg);

    // table writes
    always_ff @(posedge aclk) begin
        if (cmd.load && (count_reg < CNT_W'(MAX_PROCS))) begin
            arrival_mem[count_reg[IDX_W-1:0]] <= in_arrival;
            burst_mem[count_reg[IDX_W-1:0]]   <= in_burst;
            number_mem[count_reg[IDX_W-1:0]]  <= in_number;
        end
    end

    // scan, commit and clear control
    always_comb begin
        finished_next = finished_reg;
        count_next    = count_reg;
        done_next     = done_reg;
        clock_next    = clock_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bw_next       = bw_reg;
        bb_next       = bb_reg;
        ba_next       = ba_reg;
        next_arr_next = next_arr_reg;
        if (cmd.load && (count_reg < CNT_W'(MAX_PROCS))) begin
            count_next = count_reg + CNT_W'(1);
            finished_next[count_reg[IDX_W-1:0]] = 1'b0;
        end
        if (cmd.scan_init) begin
            idx_next      = '0;
            found_next    = 1'b0;
            next_arr_next = '1;
        end
        if (cmd.scan_step) begin
            if (eligible && better) begin
                found_next = 1'b1;
                best_next  = idx;
                bw_next    = cur_w;
                bb_next    = cur_b;
                ba_next    = cur_a;
            end
            if (!finished_reg[idx] && ({1'b0, cur_a} < next_arr_reg))
                next_arr_next = {1'b0, cur_a};
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.commit) begin
            if (found_reg) begin
                clock_next = seg_completion;
                finished_next[best_reg] = 1'b1;
                done_next = done_reg + CNT_W'(1);
            end else begin
                clock_next = TIME_W'(next_arr_reg[ARR_W-1:0]);
            end
        end
        if (cmd.clear) begin
            finished_next = '0;
            count_next    = '0;
            done_next     = '0;
            clock_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finished_reg <= '0;
            count_reg    <= '0;
            done_reg     <= '0;
            clock_reg    <= '0;
            found_reg    <= 1'b0;
            idx_reg      <= '0;
        end else begin
            finished_reg <= finished_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            clock_reg    <= clock_next;
            found_reg    <= found_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg     <= best_next;
        bw_reg       <= bw_next;
        bb_reg       <= bb_next;
        ba_reg       <= ba_next;
        next_arr_reg <= next_arr_next;
    end

    // segment fields from the chosen process or the idle gap
    always_comb begin
        seg_idle   = !found_reg;
        seg_start  = clock_reg;
        if (found_reg) begin
            seg_number     = number_mem[best_reg];
            seg_completion = clock_reg + TIME_W'(bb_reg);
            seg_turnaround = seg_completion - TIME_W'(ba_reg);
            seg_waiting    = seg_turnaround - TIME_W'(bb_reg);
            seg_response   = clock_reg - TIME_W'(ba_reg);
        end else begin
            seg_number     = '0;
            seg_completion = TIME_W'(next_arr_reg[ARR_W-1:0]);
            seg_turnaround = '0;
            seg_waiting    = '0;
            seg_response   = '0;
        end
    end

endmodule

// ===== rtl/core/hrrn_ctrl.sv =====
// hrrn scheduler controller: load, scan, emit and clear sequencing
module hrrn_ctrl
    import hrrn_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_last,
    output logic          s_ready,
    input  hrrn_status_t  status,
    output hrrn_cmd_t     cmd,
    input  logic          out_free,
    output logic          out_load,
    output logic          out_last
);

    hrrn_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_LOAD;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) state_next = ST_SCAN_INIT;
                end
            end
            ST_SCAN_INIT: begin
                if (status.all_done) begin
                    state_next = ST_CLEAR;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_SCAN_INIT;
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
        // last segment when the commit finishes the final process
        out_last = out_load && status.final_seg;
    end

endmodule

// ===== rtl/core/hrrn_scheduler.sv =====
// hrrn scheduler top level: stream ports, output register and assertions
// Process beats load into a 16-entry table at one beat per cycle. The beat
// with tlast starts the schedule: for each segment the controller scans the
// table once (one entry per cycle, ratio compare on a single multiplier
// pair), then goes through ST_DECIDE to ST_EMIT, which waits until the
// output register is free. Input is not taken during a run. Results leave
// through an output register with tlast on the final segment; the table
// clears itself through ST_SCAN_INIT and ST_CLEAR after that segment.
module hrrn_scheduler
    import hrrn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // process_number[7:0], arrival_time[23:8], burst_time[39:24]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // process_number_res[7:0], start_time[28:8], completion_time[49:29],
    // turnaround_time[70:50], waiting_time[91:71], response_time[112:92]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // idle_segment[0]
    output logic [M_TUSER_W-1:0]  m_tuser,
    output logic                  m_tlast
);

    hrrn_cmd_t    cmd;
    hrrn_status_t status;
    logic out_load, out_last, out_free;
    logic seg_idle;
    logic [NUM_W-1:0]  seg_number;
    logic [TIME_W-1:0] seg_start, seg_comp, seg_tat, seg_wt, seg_rt;
    logic m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic m_idle_reg, m_last_reg;
    logic s_ready;

    assign s_tready = s_ready;

    hrrn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_last   (s_tlast),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd),
        .out_free (out_free),
        .out_load (out_load),
        .out_last (out_last)
    );

    hrrn_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_number      (s_tdata[7:0]),
        .in_arrival     (s_tdata[23:8]),
        .in_burst       (s_tdata[39:24]),
        .status         (status),
        .seg_idle       (seg_idle),
        .seg_number     (seg_number),
        .seg_start      (seg_start),
        .seg_completion (seg_comp),
        .seg_turnaround (seg_tat),
        .seg_waiting    (seg_wt),
        .seg_response   (seg_rt)
    );

    // output register, refilled as the current beat leaves
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {7'd0, seg_rt, seg_wt, seg_tat, seg_comp, seg_start, seg_number};
            m_idle_reg <= seg_idle;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_idle_reg;
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    // no new process beats while a run is in flight
    a_no_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step || cmd.commit) |-> !s_tready)
        else $error("input taken during schedule run");

    // a result is only loaded when the register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten");

    // clear follows only a finished run
    a_clear_after_all: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> status.all_done)
        else $error("table cleared with processes pending");
`endif

endmodule
